/* src/vmp_pkg.sv */
package vmp_pkg;

    // Default fixed-point format and matrix count
    localparam int COEFF_FRAC_BITS_DEF = 16;
    localparam int NUM_MATRICES_DEF    = 3;

    // Widest divider numerator: 32-bit magnitude shifted by up to 24 fraction bits
    localparam int DIV_W_MAX = 56;

    // Input item codes
    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_WZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // Item traveling down the matrix cells: a load or a vector
    typedef struct packed {
        logic              valid;
        logic              is_load;
        logic [1:0]        sel;
        logic [3:0]        idx;
        logic [31:0]       value;
        logic [3:0][31:0]  vec;
        logic              sat;
        logic              last;
    } vmp_xf_t;

    // Item traveling down the divider cells: two unsigned divides by |w|
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 sat;
        logic                 wzero;
        logic                 negx;
        logic                 negy;
        logic [DIV_W_MAX-1:0] nx;
        logic [DIV_W_MAX-1:0] ny;
        logic [DIV_W_MAX-1:0] qx;
        logic [DIV_W_MAX-1:0] qy;
        logic [32:0]          rx;
        logic [32:0]          ry;
        logic [31:0]          dm;
    } vmp_div_t;

endpackage

/* src/vmp_in_if.sv */
interface vmp_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [1:0]         matrix_select;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               last_point;

    modport source (
        output valid, mode, matrix_select, coeff_index, coeff_value,
               point_x, point_y, point_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, mode, matrix_select, coeff_index, coeff_value,
               point_x, point_y, point_z, last_point,
        output ready
    );
endinterface

/* src/vmp_out_if.sv */
interface vmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [1:0]         status;
    logic               end_of_path;

    modport source (
        output valid, screen_x, screen_y, status, end_of_path,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, status, end_of_path,
        output ready
    );
endinterface

/* src/vmp_matrix_cell.sv */
module vmp_matrix_cell
    import vmp_pkg::*;
#(
    parameter int CELL_INDEX      = 0,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  vmp_xf_t item_in,
    output vmp_xf_t item_out
);

    localparam logic [1:0] SEL = 2'(CELL_INDEX);
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    logic [15:0][31:0]  coef_reg;
    vmp_xf_t            mid_reg;
    logic signed [63:0] prod_reg [16];
    logic signed [63:0] prod_next [16];
    vmp_xf_t            out_reg;
    vmp_xf_t            out_next;

    // Coefficients of this matrix; a load updates them in stream order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (en && item_in.valid && item_in.is_load && item_in.sel == SEL)
        begin
            coef_reg[item_in.idx] <= item_in.value;
        end
    end

    // Sixteen products, row r uses coefficients m[4j+r]
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[4*r+j] = $signed(coef_reg[4*j+r]) * $signed(item_in.vec[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            mid_reg <= item_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Row sums, floor shift and saturation
    always_comb
    begin
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        out_next = mid_reg;
        for (int r = 0; r < 4; r++)
        begin
            sum = 66'(prod_reg[4*r]) + 66'(prod_reg[4*r+1])
                + 66'(prod_reg[4*r+2]) + 66'(prod_reg[4*r+3]);
            sh = sum >>> COEFF_FRAC_BITS;
            if (sh > SAT_MAX)
            begin
                out_next.vec[r] = 32'h7FFF_FFFF;
                out_next.sat    = 1'b1;
            end
            else if (sh < SAT_MIN)
            begin
                out_next.vec[r] = 32'h8000_0000;
                out_next.sat    = 1'b1;
            end
            else
            begin
                out_next.vec[r] = sh[31:0];
            end
        end
        if (mid_reg.is_load)
        begin
            out_next.sat = mid_reg.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign item_out = out_reg;

endmodule

/* src/vmp_div_cell.sv */
module vmp_div_cell
    import vmp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  vmp_div_t item_in,
    output vmp_div_t item_out
);

    vmp_div_t out_reg;
    vmp_div_t out_next;

    // One restoring step for both lanes
    always_comb
    begin
        logic [32:0] rx_sh;
        logic [32:0] ry_sh;
        out_next = item_in;
        rx_sh = {item_in.rx[31:0], item_in.nx[BIT]};
        ry_sh = {item_in.ry[31:0], item_in.ny[BIT]};
        if (rx_sh >= {1'b0, item_in.dm})
        begin
            out_next.rx      = rx_sh - {1'b0, item_in.dm};
            out_next.qx[BIT] = 1'b1;
        end
        else
        begin
            out_next.rx = rx_sh;
        end
        if (ry_sh >= {1'b0, item_in.dm})
        begin
            out_next.ry      = ry_sh - {1'b0, item_in.dm};
            out_next.qy[BIT] = 1'b1;
        end
        else
        begin
            out_next.ry = ry_sh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign item_out = out_reg;

endmodule

/* src/vertex_mvp_transform_project_core.sv */
// Channel   Dir  Payload
// in_chan   in   mode, matrix_select, coeff_index, coeff_value, point_x/y/z, last_point
// out_chan  out  screen_x, screen_y, status, end_of_path (one per transform request)
//
// One request per cycle while out_chan is not stalled. Each matrix cell registers its
// products, then its row sums; the divider chain has one register per quotient bit.
// Reset clears the coefficient registers and all valid bits at once.
// A stalled output register holds the whole pipeline; in_chan.ready follows it.
module vertex_mvp_transform_project_core
    import vmp_pkg::*;
#(
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
    parameter int NUM_MATRICES    = NUM_MATRICES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    vmp_in_if.sink    in_chan,
    vmp_out_if.source out_chan
);

    localparam int NW = 32 + COEFF_FRAC_BITS;
    localparam logic [DIV_W_MAX-1:0] POS_LIM = DIV_W_MAX'(64'd2147483647);
    localparam logic [DIV_W_MAX-1:0] NEG_LIM = DIV_W_MAX'(64'd2147483648);

    logic     en;
    vmp_xf_t  xf [NUM_MATRICES+1];
    vmp_div_t dv [NW+1];

    logic               out_valid_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic [1:0]         status_reg;
    logic               eop_reg;

    assign en            = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = en;

    // Point entry: read the coordinate as Q1.15 and rescale it to COEFF_FRAC_BITS fraction bits, w = 1.0
    always_comb
    begin
        logic signed [39:0] px;
        logic signed [39:0] py;
        logic signed [39:0] pz;
        px = (40'(in_chan.point_x) <<< COEFF_FRAC_BITS) >>> 15;
        py = (40'(in_chan.point_y) <<< COEFF_FRAC_BITS) >>> 15;
        pz = (40'(in_chan.point_z) <<< COEFF_FRAC_BITS) >>> 15;
        xf[0].valid   = in_chan.valid;
        xf[0].is_load = (in_chan.mode == MODE_LOAD);
        xf[0].sel     = in_chan.matrix_select;
        xf[0].idx     = in_chan.coeff_index;
        xf[0].value   = in_chan.coeff_value;
        xf[0].vec[0]  = px[31:0];
        xf[0].vec[1]  = py[31:0];
        xf[0].vec[2]  = pz[31:0];
        xf[0].vec[3]  = 32'(64'd1 << COEFF_FRAC_BITS);
        xf[0].sat     = 1'b0;
        xf[0].last    = in_chan.last_point;
    end

    // Matrix cells: world, view, projection
    for (genvar k = 0; k < NUM_MATRICES; k++)
    begin : g_mat
        vmp_matrix_cell #(
            .CELL_INDEX      (k),
            .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .item_in  (xf[k]),
            .item_out (xf[k+1])
        );
    end

    // Divider entry: magnitudes and signs
    always_comb
    begin
        logic [31:0] xm;
        logic [31:0] ym;
        logic [31:0] wm;
        vmp_xf_t     t;
        t  = xf[NUM_MATRICES];
        xm = t.vec[0][31] ? (~t.vec[0] + 32'd1) : t.vec[0];
        ym = t.vec[1][31] ? (~t.vec[1] + 32'd1) : t.vec[1];
        wm = t.vec[3][31] ? (~t.vec[3] + 32'd1) : t.vec[3];
        dv[0].valid = t.valid && !t.is_load;
        dv[0].last  = t.last;
        dv[0].sat   = t.sat;
        dv[0].wzero = (t.vec[3] == 32'd0);
        dv[0].negx  = t.vec[0][31] ^ t.vec[3][31];
        dv[0].negy  = t.vec[1][31] ^ t.vec[3][31];
        dv[0].nx    = {{(DIV_W_MAX-32){1'b0}}, xm} << COEFF_FRAC_BITS;
        dv[0].ny    = {{(DIV_W_MAX-32){1'b0}}, ym} << COEFF_FRAC_BITS;
        dv[0].qx    = '0;
        dv[0].qy    = '0;
        dv[0].rx    = '0;
        dv[0].ry    = '0;
        dv[0].dm    = wm;
    end

    // Divider cells, one quotient bit each, most significant first
    for (genvar s = 0; s < NW; s++)
    begin : g_div
        vmp_div_cell #(
            .BIT (NW - 1 - s)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .item_in  (dv[s]),
            .item_out (dv[s+1])
        );
    end

    // Sign, saturation, status and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            status_reg    <= STATUS_OK;
            eop_reg       <= 1'b0;
        end
        else if (en)
        begin
            logic sat;
            logic signed [31:0] vx;
            logic signed [31:0] vy;
            vmp_div_t d;
            d   = dv[NW];
            sat = d.sat;
            if (d.negx)
            begin
                if (d.qx > NEG_LIM)
                begin
                    vx  = 32'sh8000_0000;
                    sat = 1'b1;
                end
                else
                begin
                    vx = ~d.qx[31:0] + 32'd1;
                end
            end
            else if (d.qx > POS_LIM)
            begin
                vx  = 32'sh7FFF_FFFF;
                sat = 1'b1;
            end
            else
            begin
                vx = d.qx[31:0];
            end
            if (d.negy)
            begin
                if (d.qy > NEG_LIM)
                begin
                    vy  = 32'sh8000_0000;
                    sat = 1'b1;
                end
                else
                begin
                    vy = ~d.qy[31:0] + 32'd1;
                end
            end
            else if (d.qy > POS_LIM)
            begin
                vy  = 32'sh7FFF_FFFF;
                sat = 1'b1;
            end
            else
            begin
                vy = d.qy[31:0];
            end
            out_valid_reg <= d.valid;
            eop_reg       <= d.last;
            if (d.wzero)
            begin
                sx_reg     <= '0;
                sy_reg     <= '0;
                status_reg <= STATUS_WZERO;
            end
            else
            begin
                sx_reg     <= vx;
                sy_reg     <= vy;
                status_reg <= sat ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.screen_x    = sx_reg;
    assign out_chan.screen_y    = sy_reg;
    assign out_chan.status      = status_reg;
    assign out_chan.end_of_path = eop_reg;

endmodule

/* test/tb.sv */
module tb;
    import vmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = COEFF_FRAC_BITS_DEF;
    localparam int NMAT     = NUM_MATRICES_DEF;
    localparam int LATENCY  = 2 * NMAT + 32 + FRAC;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 530;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    typedef struct {
        logic              mode;
        logic [1:0]        msel;
        logic [3:0]        idx;
        logic [31:0]       value;
        logic [15:0]       px, py, pz;
        logic              last;
        bit                has_fixed;   // expected result typed in below
        logic [31:0]       fx, fy;
        logic [1:0]        fst;
    } request_t;

    typedef struct {
        logic [31:0] sx, sy;
        logic [1:0]  st;
        logic        eop;
    } screen_pt_t;

    logic clk = 1'b0;
    logic rst_n;
    vmp_in_if  in_chan ();
    vmp_out_if out_chan ();

    vertex_mvp_transform_project_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan.sink),
        .out_chan (out_chan.source)
    );

    // Predictor state
    logic [31:0] coeffs [16*NMAT];
    screen_pt_t  pending_pts [$];
    int          mismatches;
    int          idle_cycles = 0;
    bit          calm;          // stretch with no idling

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint floor_div(longint v, int s);
        return v >>> s;         // arithmetic shift floors
    endfunction

    function automatic longint clip32(longint v, ref bit sat);
        if (v > S32MAX)
        begin
            sat = 1'b1;
            return S32MAX;
        end
        if (v < S32MIN)
        begin
            sat = 1'b1;
            return S32MIN;
        end
        return v;
    endfunction

    // Transform one point through every matrix and divide by w
    function automatic screen_pt_t project_point(request_t r);
        longint    v [4];
        longint    nv [4];
        logic signed [127:0] acc;
        logic signed [127:0] q;
        bit        sat;
        screen_pt_t p;
        sat = 1'b0;
        v[0] = floor_div(longint'($signed(r.px)) <<< FRAC, 15);
        v[1] = floor_div(longint'($signed(r.py)) <<< FRAC, 15);
        v[2] = floor_div(longint'($signed(r.pz)) <<< FRAC, 15);
        v[3] = longint'(1) <<< FRAC;
        for (int k = 0; k < NMAT; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                acc = 0;
                for (int j = 0; j < 4; j++)
                    acc += 128'(longint'($signed(coeffs[16*k + 4*j + i]))) * 128'(v[j]);
                acc = acc >>> FRAC;
                if (acc > S32MAX)
                begin
                    sat = 1'b1;
                    nv[i] = S32MAX;
                end
                else if (acc < S32MIN)
                begin
                    sat = 1'b1;
                    nv[i] = S32MIN;
                end
                else
                    nv[i] = longint'(acc);
            end
            v = nv;
        end
        p.eop = r.last;
        if (v[3] == 0)
        begin
            p.sx = '0;
            p.sy = '0;
            p.st = STATUS_WZERO;
        end
        else
        begin
            q = (128'(v[0]) <<< FRAC) / 128'(v[3]);
            p.sx = 32'(clip32(longint'(q), sat));
            q = (128'(v[1]) <<< FRAC) / 128'(v[3]);
            p.sy = 32'(clip32(longint'(q), sat));
            p.st = sat ? STATUS_SAT : STATUS_OK;
        end
        return p;
    endfunction

    function automatic request_t load_req(logic [1:0] m, logic [3:0] i, logic [31:0] val);
        request_t r;
        r = '{default: '0};
        r.mode = MODE_LOAD;
        r.msel = m;
        r.idx = i;
        r.value = val;
        r.px = 16'($urandom);
        r.py = 16'($urandom);
        r.pz = 16'($urandom);
        r.last = 1'($urandom);
        return r;
    endfunction

    function automatic request_t point_req(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                           logic l);
        request_t r;
        r = '{default: '0};
        r.mode = MODE_TRANSFORM;
        r.msel = 2'($urandom);
        r.idx = 4'($urandom);
        r.value = $urandom;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.last = l;
        return r;
    endfunction

    // Send one request; a load updates the predictor's coefficients, a transform queues its expected result
    task automatic send(request_t r);
        screen_pt_t p;
        while (!calm && $urandom_range(99) < 19)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid         <= 1'b1;
        in_chan.mode          <= r.mode;
        in_chan.matrix_select <= r.msel;
        in_chan.coeff_index   <= r.idx;
        in_chan.coeff_value   <= r.value;
        in_chan.point_x       <= r.px;
        in_chan.point_y       <= r.py;
        in_chan.point_z       <= r.pz;
        in_chan.last_point    <= r.last;
        do
            @(posedge clk);
        while (!in_chan.ready);
        if (r.mode == MODE_LOAD)
        begin
            if (r.msel < NMAT)
                coeffs[16*r.msel + r.idx] = r.value;
        end
        else
        begin
            p = project_point(r);
            if (r.has_fixed && (p.sx !== r.fx || p.sy !== r.fy || p.st !== r.fst))
                $display("note: hand value differs from predictor");
            if (r.has_fixed)
            begin
                p.sx = r.fx;
                p.sy = r.fy;
                p.st = r.fst;
            end
            pending_pts.push_back(p);
        end
    endtask

    task automatic send_idle();
        in_chan.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random matrix: mostly near-identity small values, sometimes extreme
    task automatic load_matrix(int k, bit wild);
        logic [31:0] val;
        for (int i = 0; i < 16; i++)
        begin
            if (wild && $urandom_range(3) == 0)
                val = $urandom;
            else if (i % 5 == 0)
                val = 32'($signed($urandom_range(131072)) - 65536 + 65536);
            else
                val = 32'($signed($urandom_range(65536)) - 32768);
            send(load_req(2'(k), 4'(i), val));
        end
    endtask

    // Output side: random stall, compare with oldest expectation
    always @(posedge clk)
    begin
        screen_pt_t e;
        if (!rst_n)
            out_chan.ready <= 1'b0;
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                if (pending_pts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%h y=%h", out_chan.screen_x,
                                 out_chan.screen_y);
                end
                else
                begin
                    e = pending_pts.pop_front();
                    if (out_chan.screen_x !== e.sx || out_chan.screen_y !== e.sy ||
                        out_chan.status !== e.st || out_chan.end_of_path !== e.eop)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp x=%h y=%h st=%0d eop=%b ",
                                      "got x=%h y=%h st=%0d eop=%b"},
                                     e.sx, e.sy, e.st, e.eop, out_chan.screen_x,
                                     out_chan.screen_y, out_chan.status, out_chan.end_of_path);
                    end
                end
            end
            out_chan.ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("vertex_mvp_transform_project_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        request_t plan [$];
        request_t r;
        bit       lastp;
        int       n;
        for (int i = 0; i < 16*NMAT; i++)
            coeffs[i] = '0;
        mismatches = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_chan.valid = 1'b0;
        in_chan.mode = MODE_LOAD;
        in_chan.matrix_select = '0;
        in_chan.coeff_index = '0;
        in_chan.coeff_value = '0;
        in_chan.point_x = '0;
        in_chan.point_y = '0;
        in_chan.point_z = '0;
        in_chan.last_point = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: cleared store gives w zero, then identity matrices
        r = point_req(16'h7fff, 16'h8000, 16'h0000, 1'b1);
        r.has_fixed = 1; r.fx = '0; r.fy = '0; r.fst = STATUS_WZERO;
        plan.push_back(r);
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 4; i++)
                plan.push_back(load_req(2'(k), 4'(5*i), 32'h0001_0000));
        plan.push_back(load_req(2'd3, 4'd15, 32'h8000_0000)); // ignored select
        r = point_req(16'h4000, 16'hc000, 16'h7fff, 1'b0);
        r.has_fixed = 1; r.fx = 32'h0000_8000; r.fy = 32'hffff_8000; r.fst = STATUS_OK;
        plan.push_back(r);
        plan.push_back(point_req(16'h7fff, 16'h8000, 16'h8000, 1'b1));
        plan.push_back(load_req(2'd2, 4'd12, 32'h7fff_ffff));  // huge translation
        plan.push_back(point_req(16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
        plan.push_back(load_req(2'd2, 4'd0, 32'h8000_0000));
        plan.push_back(point_req(16'h8000, 16'h0001, 16'hffff, 1'b1));
        plan.push_back(load_req(2'd2, 4'd15, 32'h0000_0001));   // tiny w
        plan.push_back(point_req(16'h1234, 16'hedcb, 16'h0001, 1'b0));
        foreach (plan[i])
            send(plan[i]);

        // Random: matrix sets, stray single loads and point paths
        n = 0;
        while (n < N_RANDOM)
        begin
            calm = (n > 200 && n < 280);
            if ($urandom_range(9) == 0)
            begin
                // pause until the pipeline drains
                send_idle();
                while (pending_pts.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(4) == 0)
            begin
                load_matrix($urandom_range(NMAT - 1), $urandom_range(4) == 0);
                n += 16;
            end
            else if ($urandom_range(9) == 0)
            begin
                send(load_req(2'($urandom), 4'($urandom), $urandom));
                n++;
            end
            else
            begin
                for (int p = $urandom_range(1, 12); p > 0; p--)
                begin
                    lastp = (p == 1);
                    send(point_req(16'($urandom), 16'($urandom), 16'($urandom), lastp));
                    n++;
                end
            end
        end
        calm = 1'b0;
        send_idle();

        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_pts.size() == 0)
            $display("vertex_mvp_transform_project_core verification clean");
        else
            $display("vertex_mvp_transform_project_core verification failed");
        $finish;
    end

endmodule
